/* rtl/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/wshc_pkg.sv */
package wshc_pkg;

   localparam int REQ_W = 104;
   localparam int RSP_W = 392;

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [2:0] CSR_RECORD_TYPE   = 3'd0;
   localparam logic [2:0] CSR_COLLECT_MEANS = 3'd1;
   localparam logic [2:0] CSR_COLLECT_HIST  = 3'd2;
   localparam logic [2:0] CSR_HIST_LOW      = 3'd3;
   localparam logic [2:0] CSR_HIST_HIGH     = 3'd4;
   localparam logic [2:0] CSR_BIN_SHIFT     = 3'd5;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

endpackage

/* rtl/wshc_ram.sv */
module wshc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/wshc_mul.sv */
module wshc_mul import wshc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output logic        mul_done,
   output logic [63:0] mul_prod
);

   logic [1:0]  step_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [63:0] a_ff;
   logic [63:0] b_ff;
   logic [63:0] acc_ff;
   logic [31:0] x;
   logic [31:0] y;
   logic [63:0] prod;
   logic [63:0] acc_in;

   // low x low, then the two cross terms shifted up, all mod 2^64
   always_comb begin
      x      = (step_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
      y      = (step_ff == 2'd1) ? b_ff[63:32] : b_ff[31:0];
      prod   = 64'(x) * 64'(y);
      acc_in = (step_ff == 2'd0) ? prod : acc_ff + {prod[31:0], 32'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && !mul_req.start && (step_ff == 2'd2);
         if (mul_req.start) begin
            a_ff    <= mul_req.a;
            b_ff    <= mul_req.b;
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (busy_ff) begin
            acc_ff <= acc_in;
            if (step_ff == 2'd2) begin
               busy_ff <= 1'b0;
            end else begin
               step_ff <= step_ff + 2'd1;
            end
         end
      end
   end

   assign mul_done = done_ff;
   assign mul_prod = acc_ff;

endmodule

/* rtl/weighted_stats_histogram_collector.sv */
// Weighted statistics collector with a histogram held in block RAM.
// req channel carries one command transaction: opcode, sample value,
// weight or timestamp and a bin index. rsp channel returns one status
// transaction per command with the counters after that command.
// csr port writes the six configuration registers; write them only idle.
// An update forms three 64-bit wrapping products on one shared 32x32
// multiplier, then a bin read-modify-write, which is skipped when no bin
// is touched; a first interval sample or a no-op skips the multiplier, and
// a bin read skips the RAM with the histogram off. A clear sweeps the bin
// RAM, one entry per cycle.
// One command is in flight at a time; the next is taken as soon as the
// previous result sits in the output register.
// After reset the block sweeps all NUM_BINS bin RAM entries to zero
// with req_tready low; csr writes are taken throughout.
// When rsp_tready is held low the result stays in the output register,
// one further command may be taken and then waits for the slot.
`include "assert_macros.svh"

module weighted_stats_histogram_collector import wshc_pkg::*; #(
   parameter int NUM_BINS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // opcode, sample_value, weight_or_time, bin_index
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // sample_count, max_value, min_value, weighted_sum, weighted_square_sum,
   // total_weight, interval_error, bin_count, bin_dropped, zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   localparam int IDX_W = $clog2(NUM_BINS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DEC, S_MUL, S_BRD, S_BWR, S_FIN, S_OUT
   } state_type;

   state_type state_ff;

   logic        rec_type_ff, means_en_ff, hist_en_ff;
   logic [31:0] hist_low_ff, hist_high_ff;
   logic [4:0]  bin_shift_ff;

   logic [1:0]  op_ff;
   logic [31:0] val_ff;
   logic [63:0] wot_ff;
   logic [5:0]  bidx_ff;

   logic [63:0] count_ff, sum_ff, sqs_ff, wsum_ff, prev_t_ff;
   logic [31:0] max_ff, min_ff, prev_v_ff;
   logic        err_ff;

   logic [63:0] w_ff, sq_ff, p1_ff, p2_ff, bin_out_ff;
   logic [31:0] mval_ff;
   logic        upd_bin_ff, drop_ff, neg_ff, first_int_ff, mul_go_ff;
   logic [1:0]  phase_ff;
   logic [IDX_W-1:0] idx_ff, clr_ptr_ff;
   logic        clr_op_ff;

   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   // decode
   logic        is_point, first_int_in, neg_in, range_ok, gate, in_range, rd_ok;
   logic [63:0] iv, w_in, ax;
   logic [31:0] mv_in, max_in, min_in;
   logic [33:0] off;
   logic [32:0] idx_full;
   logic [IDX_W+5:0] bidx_ext;
   logic [IDX_W-1:0] idx_in;
   logic        mul_go_in, out_load, clr_last;

   mul_req_type mul_req;
   logic        mul_done;
   logic [63:0] mul_prod;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [63:0]      ram_wdata, ram_rdata;

   always_comb begin
      is_point     = !rec_type_ff;
      first_int_in = !is_point && (count_ff == 64'd0);
      iv           = wot_ff - prev_t_ff;
      w_in         = is_point ? wot_ff : iv;
      mv_in        = is_point ? val_ff : prev_v_ff;
      neg_in       = !is_point && iv[63];
      range_ok     = ($signed({val_ff[31], val_ff}) + $signed({hist_low_ff[31], hist_low_ff}))
                     <= $signed({hist_high_ff[31], hist_high_ff});
      gate         = hist_en_ff && (is_point ? range_ok : !neg_in);
      off          = {{2{mv_in[31]}}, mv_in} + (34'd1 << bin_shift_ff) - 34'd1
                     - {{2{hist_low_ff[31]}}, hist_low_ff};
      idx_full     = off[32:0] >> bin_shift_ff;
      in_range     = !off[33] && (idx_full < 33'(NUM_BINS));
      bidx_ext     = (IDX_W+6)'(bidx_ff);
      rd_ok        = hist_en_ff && (32'(bidx_ff) < 32'(NUM_BINS));
      idx_in       = (op_ff == OP_READ) ? bidx_ext[IDX_W-1:0] : idx_full[IDX_W-1:0];
      ax           = {{32{mval_ff[31]}}, mval_ff};
      if (is_point && count_ff == 64'd0) begin
         max_in = val_ff;
         min_in = val_ff;
      end else begin
         max_in = ($signed(val_ff) > $signed(max_ff)) ? val_ff : max_ff;
         min_in = ($signed(val_ff) < $signed(min_ff)) ? val_ff : min_ff;
      end
   end

   assign clr_last  = (32'(clr_ptr_ff) == NUM_BINS - 1);
   assign mul_go_in = (state_ff == S_DEC && op_ff == OP_UPDATE && !first_int_in)
                      || (state_ff == S_MUL && mul_done && phase_ff != 2'd2);
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      mul_req.start = mul_go_ff;
      case (phase_ff)
         2'd0: begin
            mul_req.a = ax;
            mul_req.b = ax;
         end
         2'd1: begin
            mul_req.a = ax;
            mul_req.b = w_ff;
         end
         default: begin
            mul_req.a = sq_ff;
            mul_req.b = w_ff;
         end
      endcase
      ram_we    = (state_ff == S_CLEAR) || (state_ff == S_BWR && op_ff == OP_UPDATE);
      ram_waddr = (state_ff == S_CLEAR) ? clr_ptr_ff : idx_ff;
      ram_wdata = (state_ff == S_CLEAR) ? 64'd0 : ram_rdata + w_ff;
   end

   wshc_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_done (mul_done),
      .mul_prod (mul_prod)
   );

   wshc_ram #(.WIDTH(64), .DEPTH(NUM_BINS)) u_bins (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ptr_ff   <= '0;
         clr_op_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mul_go_ff    <= 1'b0;
         phase_ff     <= 2'd0;
         rec_type_ff  <= 1'b0;
         means_en_ff  <= 1'b1;
         hist_en_ff   <= 1'b1;
         hist_low_ff  <= 32'd0;
         hist_high_ff <= 32'd63;
         bin_shift_ff <= 5'd0;
         count_ff     <= 64'd0;
         max_ff       <= 32'd0;
         min_ff       <= 32'd0;
         sum_ff       <= 64'd0;
         sqs_ff       <= 64'd0;
         wsum_ff      <= 64'd0;
         prev_t_ff    <= 64'd0;
         prev_v_ff    <= 32'd0;
         err_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RECORD_TYPE:   rec_type_ff  <= csr_wdata[0];
               CSR_COLLECT_MEANS: means_en_ff  <= csr_wdata[0];
               CSR_COLLECT_HIST:  hist_en_ff   <= csr_wdata[0];
               CSR_HIST_LOW:      hist_low_ff  <= csr_wdata;
               CSR_HIST_HIGH:     hist_high_ff <= csr_wdata;
               CSR_BIN_SHIFT:     bin_shift_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         mul_go_ff <= mul_go_in;
         case (state_ff)
            S_CLEAR: begin
               clr_ptr_ff <= clr_last ? '0 : clr_ptr_ff + 1'b1;
               if (clr_last) begin
                  state_ff <= clr_op_ff ? S_FIN : S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= req_tdata[1:0];
                  val_ff   <= req_tdata[33:2];
                  wot_ff   <= req_tdata[97:34];
                  bidx_ff  <= req_tdata[103:98];
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               w_ff         <= w_in;
               mval_ff      <= mv_in;
               neg_ff       <= neg_in;
               first_int_ff <= first_int_in;
               idx_ff       <= idx_in;
               bin_out_ff   <= 64'd0;
               upd_bin_ff   <= (op_ff == OP_UPDATE) && !first_int_in && gate && in_range;
               drop_ff      <= (op_ff == OP_UPDATE) && !first_int_in && gate && !in_range;
               phase_ff     <= 2'd0;
               case (op_ff)
                  OP_UPDATE: begin
                     state_ff <= first_int_in ? S_FIN : S_MUL;
                  end
                  OP_CLEAR: begin
                     clr_op_ff <= 1'b1;
                     state_ff  <= S_CLEAR;
                  end
                  OP_READ: begin
                     state_ff <= rd_ok ? S_BRD : S_FIN;
                  end
                  default: state_ff <= S_FIN;
               endcase
            end
            S_MUL: begin
               if (mul_done) begin
                  case (phase_ff)
                     2'd0:    sq_ff <= mul_prod;
                     2'd1:    p1_ff <= mul_prod;
                     default: p2_ff <= mul_prod;
                  endcase
                  if (phase_ff == 2'd2) begin
                     state_ff <= upd_bin_ff ? S_BRD : S_FIN;
                  end else begin
                     phase_ff <= phase_ff + 2'd1;
                  end
               end
            end
            S_BRD: state_ff <= S_BWR;
            S_BWR: begin
               if (op_ff == OP_READ) begin
                  bin_out_ff <= ram_rdata;
               end
               state_ff <= S_FIN;
            end
            S_FIN: begin
               clr_op_ff <= 1'b0;
               if (op_ff == OP_UPDATE) begin
                  count_ff <= count_ff + 64'd1;
                  if (first_int_ff) begin
                     prev_t_ff <= wot_ff;
                     prev_v_ff <= val_ff;
                     max_ff    <= 32'd0;
                     min_ff    <= 32'd0;
                  end else begin
                     max_ff <= max_in;
                     min_ff <= min_in;
                     if (neg_ff) begin
                        err_ff <= 1'b1;
                     end
                     if (rec_type_ff) begin
                        prev_t_ff <= wot_ff;
                        prev_v_ff <= val_ff;
                     end
                     if (means_en_ff) begin
                        sum_ff  <= sum_ff + p1_ff;
                        sqs_ff  <= sqs_ff + p2_ff;
                        wsum_ff <= wsum_ff + w_ff;
                     end
                  end
               end else if (op_ff == OP_CLEAR) begin
                  count_ff <= 64'd0;
                  err_ff   <= 1'b0;
                  if (means_en_ff) begin
                     sum_ff  <= 64'd0;
                     sqs_ff  <= 64'd0;
                     wsum_ff <= 64'd0;
                  end
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_data_ff <= {7'd0, drop_ff, bin_out_ff, err_ff, wsum_ff, sqs_ff,
                                  sum_ff, min_ff, max_ff, count_ff[62:0]};
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPLIES(a_idle_no_write, clock, reset, state_ff == S_IDLE, !ram_we)
   `ASSERT_IMPLIES(a_clear_blocks, clock, reset, state_ff == S_CLEAR, !req_tready)
   `ASSERT_IMPLIES(a_mul_in_phase, clock, reset, mul_done, state_ff == S_MUL)
   `ASSERT_IMPLIES(a_drop_on_update, clock, reset, state_ff == S_OUT && drop_ff, op_ff == OP_UPDATE)
   `ASSERT_NEXT(a_out_to_idle, clock, reset, state_ff == S_OUT && !rsp_valid_ff, state_ff == S_IDLE)

endmodule
